>>> hdl/assert_macros.svh
// Assertion macros used by the bearing block's output stages.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> hdl/brg_pkg.sv
// Package with the types, constants and arctangent table of the bearing block.
package brg_pkg;

   localparam int COORD_BITS = 16;
   localparam int MAG_BITS   = COORD_BITS + 1;
   localparam int FINE_BITS  = 24;
   localparam int XY_BITS    = MAG_BITS + FINE_BITS + 3;
   localparam int Z_BITS     = 33;
   localparam int FINE_W     = 34;
   localparam int TABLE_LEN  = 24;
   localparam int ANGLE_BITS = 16;

   localparam int DEF_CORDIC_STEPS    = 16;
   localparam int DEF_ANGLE_FRAC_BITS = 7;

   localparam logic [FINE_W-1:0] FINE_90  = FINE_W'(64'd90  << FINE_BITS);
   localparam logic [FINE_W-1:0] FINE_180 = FINE_W'(64'd180 << FINE_BITS);
   localparam logic [FINE_W-1:0] FINE_270 = FINE_W'(64'd270 << FINE_BITS);
   localparam logic [FINE_W-1:0] FINE_360 = FINE_W'(64'd360 << FINE_BITS);

   typedef enum logic [1:0] {
      BRG_EAST  = 2'd0,
      BRG_NORTH = 2'd1,
      BRG_WEST  = 2'd2,
      BRG_SOUTH = 2'd3
   } brg_dir_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] from_x;
      logic signed [COORD_BITS-1:0] from_y;
      logic signed [COORD_BITS-1:0] to_x;
      logic signed [COORD_BITS-1:0] to_y;
   } brg_req_type;

   typedef struct packed {
      logic [ANGLE_BITS-1:0] angle;
      logic [1:0]            quadrant_dir;
   } brg_rsp_type;

   // Signs and zero flags of the two offsets, carried alongside the rotation.
   typedef struct packed {
      logic dx_neg;
      logic dy_neg;
      logic dx_zero;
      logic dy_zero;
   } brg_quad_type;

   typedef struct packed {
      logic signed [XY_BITS-1:0] x;
      logic signed [XY_BITS-1:0] y;
      logic signed [Z_BITS-1:0]  z;
      brg_quad_type              quad;
   } brg_cordic_type;

   // atan(2^-step) in units of 2^-24 degree, rounded to nearest.
   function automatic logic [Z_BITS-1:0] brg_atan(input int step);
      logic [Z_BITS-1:0] val;
      case (step)
         0:       val = Z_BITS'(754974720);
         1:       val = Z_BITS'(445687602);
         2:       val = Z_BITS'(235489088);
         3:       val = Z_BITS'(119537938);
         4:       val = Z_BITS'(60000934);
         5:       val = Z_BITS'(30029717);
         6:       val = Z_BITS'(15018523);
         7:       val = Z_BITS'(7509720);
         8:       val = Z_BITS'(3754917);
         9:       val = Z_BITS'(1877466);
         10:      val = Z_BITS'(938734);
         11:      val = Z_BITS'(469367);
         12:      val = Z_BITS'(234684);
         13:      val = Z_BITS'(117342);
         14:      val = Z_BITS'(58671);
         15:      val = Z_BITS'(29335);
         16:      val = Z_BITS'(14668);
         17:      val = Z_BITS'(7334);
         18:      val = Z_BITS'(3667);
         19:      val = Z_BITS'(1833);
         20:      val = Z_BITS'(917);
         21:      val = Z_BITS'(458);
         22:      val = Z_BITS'(229);
         23:      val = Z_BITS'(115);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

>>> hdl/brg_prep.sv
// Input stage: forms the offsets, their magnitudes and the quadrant flags.
module brg_prep
   import brg_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           up_valid,
   output logic           up_ready,
   input  brg_req_type    up_word,
   output logic           dn_valid,
   input  logic           dn_ready,
   output brg_cordic_type dn_word
);

   logic signed [MAG_BITS-1:0] dx;
   logic signed [MAG_BITS-1:0] dy;
   logic [MAG_BITS-1:0]        ax;
   logic [MAG_BITS-1:0]        ay;
   brg_cordic_type             word_in;
   brg_cordic_type             word_ff;
   logic                       valid_ff;

   always_comb begin
      dx = MAG_BITS'(up_word.to_x) - MAG_BITS'(up_word.from_x);
      dy = MAG_BITS'(up_word.from_y) - MAG_BITS'(up_word.to_y);
      ax = dx[MAG_BITS-1] ? MAG_BITS'(-dx) : MAG_BITS'(dx);
      ay = dy[MAG_BITS-1] ? MAG_BITS'(-dy) : MAG_BITS'(dy);
      word_in.x            = $signed(XY_BITS'({ax, FINE_BITS'(0)}));
      word_in.y            = $signed(XY_BITS'({ay, FINE_BITS'(0)}));
      word_in.z            = '0;
      word_in.quad.dx_neg  = dx[MAG_BITS-1];
      word_in.quad.dy_neg  = dy[MAG_BITS-1];
      word_in.quad.dx_zero = (dx == '0);
      word_in.quad.dy_zero = (dy == '0);
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         word_ff <= word_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_word  = word_ff;

endmodule

>>> hdl/brg_cordic_stage.sv
// One registered CORDIC vectoring iteration.
module brg_cordic_stage
   import brg_pkg::*;
#(
   parameter int STEP = 0
)(
   input  logic           clock,
   input  logic           reset,
   input  logic           up_valid,
   output logic           up_ready,
   input  brg_cordic_type up_word,
   output logic           dn_valid,
   input  logic           dn_ready,
   output brg_cordic_type dn_word
);

   localparam logic signed [Z_BITS-1:0] ATAN = $signed(brg_atan(STEP));

   logic signed [XY_BITS-1:0] xs;
   logic signed [XY_BITS-1:0] ys;
   brg_cordic_type            word_in;
   brg_cordic_type            word_ff;
   logic                      valid_ff;

   always_comb begin
      xs      = up_word.x >>> STEP;
      ys      = up_word.y >>> STEP;
      word_in = up_word;
      // Rotate toward the x axis; the sign of y picks the direction.
      if (!up_word.y[XY_BITS-1]) begin
         word_in.x = up_word.x + ys;
         word_in.y = up_word.y - xs;
         word_in.z = up_word.z + ATAN;
      end else begin
         word_in.x = up_word.x - ys;
         word_in.y = up_word.y + xs;
         word_in.z = up_word.z - ATAN;
      end
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         word_ff <= word_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_word  = word_ff;

endmodule

>>> hdl/brg_post.sv
// Output stages: saturate and fold the angle, then round, wrap and classify.
module brg_post
   import brg_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
)(
   input  logic           clock,
   input  logic           reset,
   input  logic           up_valid,
   output logic           up_ready,
   input  brg_cordic_type up_word,
   output logic           dn_valid,
   input  logic           dn_ready,
   output brg_rsp_type    dn_word
);

`include "assert_macros.svh"

   localparam int ANG_W = 9 + ANGLE_FRAC_BITS;
   localparam int SHIFT = FINE_BITS - ANGLE_FRAC_BITS;
   localparam logic [FINE_W:0]    HALF  = (FINE_W + 1)'(64'd1 << (SHIFT - 1));
   localparam logic [ANG_W-1:0]   FULL  = ANG_W'(64'd360 << ANGLE_FRAC_BITS);
   localparam logic [ANG_W-1:0]   T45   = ANG_W'(64'd45  << ANGLE_FRAC_BITS);
   localparam logic [ANG_W-1:0]   T135  = ANG_W'(64'd135 << ANGLE_FRAC_BITS);
   localparam logic [ANG_W-1:0]   T225  = ANG_W'(64'd225 << ANGLE_FRAC_BITS);
   localparam logic [ANG_W-1:0]   T315  = ANG_W'(64'd315 << ANGLE_FRAC_BITS);

   // Fold stage.
   logic [FINE_W-1:0] t;
   logic [FINE_W-1:0] fine_in;
   logic [FINE_W-1:0] fine_ff;
   logic              fold_valid_ff;
   logic              fold_ready;

   always_comb begin
      if (up_word.z[Z_BITS-1]) begin
         t = '0;
      end else if (FINE_W'($unsigned(up_word.z)) > FINE_90) begin
         t = FINE_90;
      end else begin
         t = FINE_W'($unsigned(up_word.z));
      end

      if (up_word.quad.dx_zero && up_word.quad.dy_zero) begin
         fine_in = '0;
      end else if (up_word.quad.dy_zero) begin
         fine_in = up_word.quad.dx_neg ? FINE_180 : '0;
      end else if (up_word.quad.dx_zero) begin
         fine_in = up_word.quad.dy_neg ? FINE_270 : FINE_90;
      end else if (!up_word.quad.dx_neg && !up_word.quad.dy_neg) begin
         fine_in = t;
      end else if (up_word.quad.dx_neg && !up_word.quad.dy_neg) begin
         fine_in = FINE_180 - t;
      end else if (up_word.quad.dx_neg) begin
         fine_in = FINE_180 + t;
      end else begin
         fine_in = FINE_360 - t;
      end
   end

   // Round stage.
   logic [FINE_W:0]     sum;
   logic [ANG_W-1:0]    ang_raw;
   logic [ANG_W-1:0]    ang_in;
   logic [ANG_W-1:0]    ang_ff;
   brg_dir_type         dir_in;
   brg_dir_type         dir_ff;
   logic [ANG_W+15:0]   ang_ext;
   logic                out_valid_ff;

   always_comb begin
      sum     = (FINE_W + 1)'(fine_ff) + HALF;
      ang_raw = ANG_W'(sum >> SHIFT);
      ang_in  = (ang_raw >= FULL) ? ang_raw - FULL : ang_raw;
      if (ang_in <= T45 || ang_in >= T315) begin
         dir_in = BRG_EAST;
      end else if (ang_in <= T135) begin
         dir_in = BRG_NORTH;
      end else if (ang_in <= T225) begin
         dir_in = BRG_WEST;
      end else begin
         dir_in = BRG_SOUTH;
      end
   end

   assign fold_ready = !out_valid_ff || dn_ready;
   assign up_ready   = !fold_valid_ff || fold_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (up_ready) begin
            fold_valid_ff <= up_valid;
         end
         if (fold_ready) begin
            out_valid_ff <= fold_valid_ff;
         end
      end
      if (up_ready && up_valid) begin
         fine_ff <= fine_in;
      end
      if (fold_ready && fold_valid_ff) begin
         ang_ff <= ang_in;
         dir_ff <= dir_in;
      end
   end

   // Wide angle formats keep only the low 16 bits.
   assign ang_ext              = {16'b0, ang_ff};
   assign dn_valid             = out_valid_ff;
   assign dn_word.angle        = ang_ext[15:0];
   assign dn_word.quadrant_dir = dir_ff;

   `ASSERT_SAME(a_fine_range, clock, reset, fold_valid_ff, fine_ff <= FINE_360)
   `ASSERT_SAME(a_ang_range, clock, reset, out_valid_ff, ang_ff < FULL)
   `ASSERT_SAME(a_south_range, clock, reset, out_valid_ff && dir_ff == BRG_SOUTH,
                ang_ff > T225 && ang_ff < T315)
   `ASSERT_NEXT(a_out_hold, clock, reset, out_valid_ff && !dn_ready,
                out_valid_ff && $stable(ang_ff))

endmodule

>>> hdl/bearing_angle_degrees_top.sv
// Top level of the bearing block: input stage, CORDIC pipeline and output stages.
//
// This block returns the bearing from the first screen point to the second
// (y grows downward) as atan2(from_y - to_y, to_x - from_x) in degrees,
// counterclockwise from east, in units of 1/2^ANGLE_FRAC_BITS degree within
// [0, 360), together with a four-way direction code (right, up, left, down).
// Coincident points give 0, and purely horizontal or vertical offsets give
// exactly 0, 90, 180 or 270 degrees. The block is a fully pipelined CORDIC
// vectoring engine: one input word can be taken every clock cycle while the
// result channel is not stalled, and a word passes one input stage, one stage
// per rotation step, capped at 24, and two output stages for folding and
// rounding. Every stage carries its own valid bit and can fill while the
// stages after it are stalled, so back-pressure on the result channel only
// stops the input once every stage holds a word. The ready on the input
// channel is a combinational function of the result channel's ready and the
// stage occupancy.
module bearing_angle_degrees_top
   import brg_pkg::*;
#(
   parameter int CORDIC_STEPS    = DEF_CORDIC_STEPS,
   parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  brg_req_type req_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output brg_rsp_type rsp_word
);

   // Rotation steps beyond the arctangent table are not taken.
   localparam int STAGES = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

   // Word, valid and ready between the stages; index 0 is the input stage's output.
   brg_cordic_type pipe_word  [0:STAGES];
   logic           pipe_valid [0:STAGES];
   logic           pipe_ready [0:STAGES];

   brg_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_valid),
      .up_ready (req_ready),
      .up_word  (req_word),
      .dn_valid (pipe_valid[0]),
      .dn_ready (pipe_ready[0]),
      .dn_word  (pipe_word[0])
   );

   // One registered rotation per stage, each with its own fixed shift.
   for (genvar s = 0; s < STAGES; s++) begin : g_step
      brg_cordic_stage #(
         .STEP (s)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .up_valid (pipe_valid[s]),
         .up_ready (pipe_ready[s]),
         .up_word  (pipe_word[s]),
         .dn_valid (pipe_valid[s+1]),
         .dn_ready (pipe_ready[s+1]),
         .dn_word  (pipe_word[s+1])
      );
   end

   // Saturation, quadrant fold, rounding and direction classification.
   brg_post #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_post (
      .clock    (clock),
      .reset    (reset),
      .up_valid (pipe_valid[STAGES]),
      .up_ready (pipe_ready[STAGES]),
      .up_word  (pipe_word[STAGES]),
      .dn_valid (rsp_valid),
      .dn_ready (rsp_ready),
      .dn_word  (rsp_word)
   );

endmodule
